[src/tts_route_pkg.sv]
package tts_route_pkg;

    localparam int END_W    = 10;
    localparam int IN_W_W   = 32;
    localparam int ROUTE_W  = 43;
    localparam int NCFG_W   = 11;
    localparam logic [NCFG_W-1:0] NODE_COUNT_RESET = 11'd1024;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_SOLVE = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [END_W-1:0]  end_first;
        logic [END_W-1:0]  end_second;
        logic [IN_W_W-1:0] edge_weight;
        logic [END_W-1:0]  terminal_a;
        logic [END_W-1:0]  terminal_b;
        logic [END_W-1:0]  terminal_c;
    } t_item;

    typedef struct packed {
        logic [ROUTE_W-1:0] route_length;
        logic               found;
        logic               edge_overflow;
    } t_result;

endpackage

[src/three_terminal_shortest_route_core.sv]
// Clear and add items leave busy low and no result follows.
// Solve with a terminal out of range: result strobe the cycle after the transfer, busy low.
// Solve: two searches, each clearing the node table, a seed step, per visited node a minimum
// scan over all nodes, a mark step and a request, check and optional update per stored edge,
// then a final scan; then the terminal distances are captured and three terminal orders compared.
// o_done lasts one cycle and cannot be stalled; i_rst_n is synchronous, active low.
module three_terminal_shortest_route_core #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tts_route_pkg::t_item   i_item,
    output logic                   o_done,
    output tts_route_pkg::t_result o_result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import tts_route_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NC_W   = $clog2(MAX_NODES + 1);
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DIST_W = WEIGHT_BITS + NODE_W;
    localparam int NM_W   = DIST_W + 2;
    localparam int EM_W   = 2 * END_W + WEIGHT_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_SEED = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_SCMP = 4'd4;
    localparam logic [3:0] S_MARK = 4'd5;
    localparam logic [3:0] S_EREQ = 4'd6;
    localparam logic [3:0] S_ECHK = 4'd7;
    localparam logic [3:0] S_EUPD = 4'd8;
    localparam logic [3:0] S_CRQ  = 4'd9;
    localparam logic [3:0] S_CAP  = 4'd10;
    localparam logic [3:0] S_ORD  = 4'd11;

    logic [3:0]        r_state;
    logic [NCFG_W-1:0] r_node_count;
    logic [EC_W-1:0]   r_edge_total;
    logic              r_overflow;
    logic [END_W-1:0]  r_ta, r_tb, r_tc;
    logic              r_p;
    logic              r_q;
    logic [1:0]        r_k;
    logic [NC_W-1:0]   r_idx;
    logic [EC_W-1:0]   r_e;
    logic              r_have;
    logic [NODE_W-1:0] r_best;
    logic [DIST_W-1:0] r_bestd;
    logic [NODE_W-1:0] r_tgt;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [DIST_W-1:0] r_dab, r_dac, r_dbc;
    logic              r_rab, r_rac, r_rbc;
    logic              r_found;
    logic [DIST_W:0]   r_route;
    logic              r_done;
    t_result           r_result;

    logic [NM_W-1:0]   r_nmem [MAX_NODES];
    logic [NM_W-1:0]   r_nrd;
    logic              nm_we;
    logic [NODE_W-1:0] nm_wa, nm_ra;
    logic [NM_W-1:0]   nm_wd;

    logic [EM_W-1:0]   r_emem [MAX_EDGES];
    logic [EM_W-1:0]   r_erd;
    logic              em_we;
    logic [EA_W-1:0]   em_wa, em_ra;
    logic [EM_W-1:0]   em_wd;

    logic [NC_W-1:0]   n_eff;
    logic              accept;
    logic              cfg_wr;

    logic              nd_reached, nd_visited;
    logic [DIST_W-1:0] nd_dist;
    logic [END_W-1:0]  e_u, e_v;
    logic [WEIGHT_BITS-1:0] e_w;
    logic              e_ok;
    logic [DIST_W-1:0] cand;
    logic              take;
    logic [END_W-1:0]  cap_term;
    logic [DIST_W:0]   ord_len;
    logic              ord_ok;

    assign n_eff  = (32'(r_node_count) > 32'(MAX_NODES)) ? NC_W'(MAX_NODES)
                                                         : NC_W'(r_node_count);
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == 3'd0) ? 32'(r_node_count) : 32'd0;
    assign o_done   = r_done;
    assign o_result = r_result;

    assign {nd_reached, nd_visited, nd_dist} = r_nrd;
    assign {e_u, e_v, e_w} = r_erd;
    assign e_ok = (32'(e_u) < 32'(n_eff)) && (32'(e_v) < 32'(n_eff))
                  && ((NODE_W'(e_u) == r_best) || (NODE_W'(e_v) == r_best));

    // candidate sum, scan compare and terminal-order sums
    always_comb begin
        cand    = r_bestd + DIST_W'(r_w);
        take    = nd_reached && !nd_visited && (!r_have || nd_dist < r_bestd);
        ord_len = '0;
        ord_ok  = 1'b0;
        case (r_k)
            2'd0: begin
                ord_len = {1'b0, r_dab} + {1'b0, r_dbc};
                ord_ok  = r_rab && r_rbc;
            end
            2'd1: begin
                ord_len = {1'b0, r_dac} + {1'b0, r_dbc};
                ord_ok  = r_rac && r_rbc;
            end
            default: begin
                ord_len = {1'b0, r_dab} + {1'b0, r_dac};
                ord_ok  = r_rab && r_rac;
            end
        endcase
        cap_term = (!r_p && !r_q) ? r_tb : r_tc;
    end

    always_comb begin
        nm_we = 1'b0;
        nm_wa = r_idx[NODE_W-1:0];
        nm_wd = '0;
        nm_ra = r_idx[NODE_W-1:0];
        unique case (r_state)
            S_CLR:  nm_we = 1'b1;
            S_SEED: begin
                nm_we = 1'b1;
                nm_wa = NODE_W'(r_p ? r_tb : r_ta);
                nm_wd = {1'b1, 1'b0, {DIST_W{1'b0}}};
            end
            S_MARK: begin
                nm_we = 1'b1;
                nm_wa = r_best;
                nm_wd = {1'b1, 1'b1, r_bestd};
            end
            S_ECHK: nm_ra = (NODE_W'(e_u) == r_best) ? NODE_W'(e_v) : NODE_W'(e_u);
            S_EUPD: begin
                nm_we = !nd_reached || (cand < nd_dist);
                nm_wa = r_tgt;
                nm_wd = {1'b1, nd_visited, cand};
            end
            S_CRQ:  nm_ra = NODE_W'(cap_term);
            default: ;
        endcase
    end

    assign em_we = accept && (i_item.kind == KIND_ADD) && (32'(r_edge_total) < 32'(MAX_EDGES));
    assign em_wa = EA_W'(r_edge_total);
    assign em_wd = {i_item.end_first, i_item.end_second, WEIGHT_BITS'(i_item.edge_weight)};
    assign em_ra = EA_W'(r_e);

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            r_nmem[nm_wa] <= nm_wd;
        end
        r_nrd <= r_nmem[nm_ra];
        if (em_we) begin
            r_emem[em_wa] <= em_wd;
        end
        r_erd <= r_emem[em_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_COUNT_RESET;
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (cfg_wr && paddr[2] == 1'b0) begin
                r_node_count <= pwdata[NCFG_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_item.kind)
                            KIND_CLEAR: begin
                                r_edge_total <= '0;
                                r_overflow   <= 1'b0;
                            end
                            KIND_ADD: begin
                                if (em_we) r_edge_total <= r_edge_total + 1'b1;
                                else       r_overflow   <= 1'b1;
                            end
                            KIND_SOLVE: begin
                                r_ta <= i_item.terminal_a;
                                r_tb <= i_item.terminal_b;
                                r_tc <= i_item.terminal_c;
                                r_p  <= 1'b0;
                                r_idx <= '0;
                                if (32'(i_item.terminal_a) < 32'(n_eff)
                                    && 32'(i_item.terminal_b) < 32'(n_eff)
                                    && 32'(i_item.terminal_c) < 32'(n_eff)) begin
                                    r_state <= S_CLR;
                                end else begin
                                    r_done   <= 1'b1;
                                    r_result <= '{route_length: '0, found: 1'b0,
                                                  edge_overflow: r_overflow};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == n_eff - 1'b1) r_state <= S_SEED;
                end
                S_SEED: begin
                    r_idx   <= '0;
                    r_have  <= 1'b0;
                    r_state <= S_SRD;
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (take) begin
                        r_have  <= 1'b1;
                        r_best  <= r_idx[NODE_W-1:0];
                        r_bestd <= nd_dist;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == n_eff - 1'b1) begin
                        if (r_have || take) begin
                            r_state <= S_MARK;
                        end else begin
                            r_q     <= r_p;
                            r_state <= S_CRQ;
                        end
                    end else begin
                        r_state <= S_SRD;
                    end
                end
                S_MARK: begin
                    r_e    <= '0;
                    r_idx  <= '0;
                    r_have <= 1'b0;
                    r_state <= (r_edge_total == '0) ? S_SRD : S_EREQ;
                end
                S_EREQ: r_state <= S_ECHK;
                S_ECHK: begin
                    r_tgt <= nm_ra;
                    r_w   <= e_w;
                    if (e_ok) begin
                        r_state <= S_EUPD;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= (r_e + 1'b1 == r_edge_total) ? S_SRD : S_EREQ;
                    end
                end
                S_EUPD: begin
                    r_e     <= r_e + 1'b1;
                    r_state <= (r_e + 1'b1 == r_edge_total) ? S_SRD : S_EREQ;
                end
                S_CRQ: r_state <= S_CAP;
                S_CAP: begin
                    if (r_p) begin
                        r_dbc   <= nd_dist;
                        r_rbc   <= nd_reached;
                        r_k     <= 2'd0;
                        r_found <= 1'b0;
                        r_state <= S_ORD;
                    end else if (!r_q) begin
                        r_dab   <= nd_dist;
                        r_rab   <= nd_reached;
                        r_q     <= 1'b1;
                        r_state <= S_CRQ;
                    end else begin
                        r_dac   <= nd_dist;
                        r_rac   <= nd_reached;
                        r_p     <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_CLR;
                    end
                end
                S_ORD: begin
                    if (ord_ok && (!r_found || ord_len < r_route)) begin
                        r_found <= 1'b1;
                        r_route <= ord_len;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                        if (ord_ok && (!r_found || ord_len < r_route)) begin
                            r_result <= '{route_length: ROUTE_W'(ord_len), found: 1'b1,
                                          edge_overflow: r_overflow};
                        end else begin
                            r_result <= '{route_length: r_found ? ROUTE_W'(r_route) : '0,
                                          found: r_found, edge_overflow: r_overflow};
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe outside idle");
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_result.found) |-> r_result.route_length == '0)
        else $error("route length without route");
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_total) <= 32'(MAX_EDGES))
        else $error("edge count overrun");
    a_solve_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.kind == KIND_SOLVE) |=> (busy || r_done))
        else $error("solve transfer dropped");

endmodule

[tb/three_terminal_shortest_route_core_tb.sv]
module three_terminal_shortest_route_core_tb;
    import tts_route_pkg::*;

    localparam int EDGE_CAP   = 4096;
    localparam int NODE_CAP   = 1024;
    localparam longint LIMIT  = 40_000_000;
    localparam int ADDR_NODES = 0;
    localparam int ITEM_GOAL  = 1300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_done;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    three_terminal_shortest_route_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // shadow of the block state
    logic [10:0] nodes_cfg = NODE_COUNT_RESET;
    logic [9:0]  edge_u [EDGE_CAP];
    logic [9:0]  edge_v [EDGE_CAP];
    logic [31:0] edge_w [EDGE_CAP];
    int          edge_cnt = 0;
    bit          dropped = 1'b0;

    t_result pending_routes[$];
    int      errors = 0;
    int      routes_seen = 0;
    int      transfers = 0;
    int      found_seen = 0;
    longint  cycles = 0;
    bit      burst = 1'b0;

    typedef struct {
        bit          is_cfg;
        logic [10:0] cfg;
        t_item       it;
        bit          typed;
        t_result     res;
    } t_row;

    t_row rows[$];

    function automatic void add_row(t_row r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic t_result shortest_route(t_item it);
        int n, p, i, e, best, k;
        int term[3];
        int ord[6][4] = '{'{0, 1, 1, 2}, '{0, 2, 2, 1}, '{1, 2, 2, 0},
                          '{1, 0, 0, 2}, '{2, 1, 1, 0}, '{2, 0, 0, 1}};
        logic [63:0] d[3][NODE_CAP];
        bit reach[3][NODE_CAP];
        bit seen[NODE_CAP];
        bit have, ok;
        logic [63:0] cand, len, shortest;
        t_result r;
        n = (nodes_cfg > NODE_CAP) ? NODE_CAP : int'(nodes_cfg);
        term[0] = it.terminal_a;
        term[1] = it.terminal_b;
        term[2] = it.terminal_c;
        ok = 1'b0;
        shortest = 0;
        if (term[0] < n && term[1] < n && term[2] < n) begin
            for (p = 0; p < 3; p++) begin
                for (i = 0; i < n; i++) begin
                    d[p][i] = 0;
                    reach[p][i] = 0;
                    seen[i] = 0;
                end
                reach[p][term[p]] = 1;
                forever begin
                    have = 0;
                    best = 0;
                    for (i = 0; i < n; i++)
                        if (reach[p][i] && !seen[i] && (!have || d[p][i] < d[p][best])) begin
                            have = 1;
                            best = i;
                        end
                    if (!have) break;
                    seen[best] = 1;
                    for (e = 0; e < edge_cnt; e++) begin
                        if (edge_u[e] >= n || edge_v[e] >= n) continue;
                        cand = d[p][best] + edge_w[e];
                        if (edge_u[e] == best)
                            if (!reach[p][edge_v[e]] || cand < d[p][edge_v[e]]) begin
                                reach[p][edge_v[e]] = 1;
                                d[p][edge_v[e]] = cand;
                            end
                        if (edge_v[e] == best)
                            if (!reach[p][edge_u[e]] || cand < d[p][edge_u[e]]) begin
                                reach[p][edge_u[e]] = 1;
                                d[p][edge_u[e]] = cand;
                            end
                    end
                end
            end
            for (k = 0; k < 6; k++)
                if (reach[ord[k][0]][term[ord[k][1]]] && reach[ord[k][2]][term[ord[k][3]]]) begin
                    len = d[ord[k][0]][term[ord[k][1]]] + d[ord[k][2]][term[ord[k][3]]];
                    if (!ok || len < shortest) begin
                        shortest = len;
                        ok = 1'b1;
                    end
                end
        end
        r.route_length = ok ? shortest[ROUTE_W-1:0] : '0;
        r.found = ok;
        r.edge_overflow = dropped;
        return r;
    endfunction

    // applies one accepted transfer to the shadow state; 1 when a result follows
    function automatic bit apply_item(t_item it, output t_result r);
        r = '0;
        case (it.kind)
            KIND_CLEAR: begin
                edge_cnt = 0;
                dropped = 0;
            end
            KIND_ADD: begin
                if (edge_cnt >= EDGE_CAP) dropped = 1;
                else begin
                    edge_u[edge_cnt] = it.end_first;
                    edge_v[edge_cnt] = it.end_second;
                    edge_w[edge_cnt] = it.edge_weight;
                    edge_cnt++;
                end
            end
            KIND_SOLVE: begin
                r = shortest_route(it);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_routes.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            routes_seen++;
            if (pending_routes.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, o_result);
            end else begin
                want = pending_routes.pop_front();
                if (want.found) found_seen++;
                if (o_result.route_length !== want.route_length) begin
                    errors++;
                    $display("%0t route_length: expected %0d actual %0d", $time,
                             want.route_length, o_result.route_length);
                end
                if (o_result.found !== want.found) begin
                    errors++;
                    $display("%0t found: expected %0b actual %0b", $time,
                             want.found, o_result.found);
                end
                if (o_result.edge_overflow !== want.edge_overflow) begin
                    errors++;
                    $display("%0t edge_overflow: expected %0b actual %0b", $time,
                             want.edge_overflow, o_result.edge_overflow);
                end
            end
        end
    end

    task automatic send(t_item it, bit typed = 0, t_result tres = '0);
        t_result r;
        int g;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        transfers++;
        if (apply_item(it, r))
            pending_routes.insert(pending_routes.size(), typed ? tres : r);
        g = burst ? 0 : $urandom_range(0, 5);
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_nodes(logic [10:0] v);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * ADDR_NODES);
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        nodes_cfg = v;
    endtask

    function automatic t_item mk(logic [1:0] k, int a, int b, longint w, int x, int y, int z);
        t_item it;
        it.kind = k;
        it.end_first = 10'(a);
        it.end_second = 10'(b);
        it.edge_weight = 32'(w);
        it.terminal_a = 10'(x);
        it.terminal_b = 10'(y);
        it.terminal_c = 10'(z);
        return it;
    endfunction

    function automatic t_row r_item(t_item it);
        t_row r;
        r.is_cfg = 0;
        r.cfg = 0;
        r.it = it;
        r.typed = 0;
        r.res = '0;
        return r;
    endfunction

    function automatic t_row r_chk(t_item it, longint len, bit f);
        t_row r;
        r = r_item(it);
        r.typed = 1;
        r.res.route_length = ROUTE_W'(len);
        r.res.found = f;
        r.res.edge_overflow = 0;
        return r;
    endfunction

    function automatic t_row r_cfg(int v);
        t_row r;
        r = r_item('0);
        r.is_cfg = 1;
        r.cfg = 11'(v);
        return r;
    endfunction

    function automatic t_item rnd_item();
        t_item it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(t_item)-1:0];
        return it;
    endfunction

    initial begin
        t_item it;
        int ph, i, n, ne, ns, lim;
        bit wide;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 0, 0, 0), 0, 1));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 5, 6, 1023), 0, 0));
        add_row(r_item(mk(2'd3, 1023, 1023, 64'hFFFF_FFFF, 1023, 1023, 1023)));
        add_row(r_item(mk(KIND_ADD, 0, 1, 64'hFFFF_FFFF, 0, 0, 0)));
        add_row(r_item(mk(KIND_ADD, 1, 2, 64'hFFFF_FFFF, 0, 0, 0)));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 0, 1, 2), 64'h1_FFFF_FFFE, 1));
        add_row(r_item(mk(KIND_SOLVE, 0, 0, 0, 2, 0, 1)));
        add_row(r_item(mk(KIND_ADD, 1023, 1022, 0, 0, 0, 0)));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 1023, 1022, 1022), 0, 1));
        add_row(r_item(mk(KIND_ADD, 1023, 0, 5, 0, 0, 0)));
        add_row(r_item(mk(KIND_SOLVE, 0, 0, 0, 1023, 2, 0)));
        add_row(r_item(mk(KIND_ADD, 3, 3, 7, 0, 0, 0)));
        add_row(r_item(mk(KIND_ADD, 4, 5, 0, 0, 0, 0)));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 3, 4, 5), 0, 0));
        add_row(r_item(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0)));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 0, 1, 2), 0, 0));
        add_row(r_item(mk(KIND_ADD, 0, 1, 3, 0, 0, 0)));
        add_row(r_item(mk(KIND_ADD, 1, 0, 1, 0, 0, 0)));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 0, 1, 1), 1, 1));
        add_row(r_cfg(2));
        add_row(r_item(mk(KIND_ADD, 0, 5, 1, 0, 0, 0)));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 0, 1, 5), 0, 0));
        add_row(r_item(mk(KIND_SOLVE, 0, 0, 0, 1, 0, 1)));
        add_row(r_cfg(0));
        add_row(r_chk(mk(KIND_SOLVE, 0, 0, 0, 0, 0, 0), 0, 0));
        add_row(r_cfg(2047));
        add_row(r_item(mk(KIND_SOLVE, 0, 0, 0, 1023, 1, 0)));

        foreach (rows[k]) begin
            if (rows[k].is_cfg) set_nodes(rows[k].cfg);
            else send(rows[k].it, rows[k].typed, rows[k].res);
        end

        // random phases: set the node count, mostly clear, load a small graph, solve a few times
        ph = 0;
        while (transfers < ITEM_GOAL) begin
            wide = ($urandom_range(0, 24) == 0);
            if (wide) n = ($urandom_range(0, 1)) ? 1024 : 2047;
            else if ($urandom_range(0, 19) == 0) n = $urandom_range(0, 1);
            else n = $urandom_range(2, 12);
            set_nodes(11'(n));
            burst = ($urandom_range(0, 3) == 0);
            lim = (n > NODE_CAP) ? NODE_CAP : n;
            if ($urandom_range(0, 7) != 0) send(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
            ne = wide ? $urandom_range(1, 8) : $urandom_range(0, 18);
            ns = wide ? $urandom_range(1, 2) : $urandom_range(1, 4);
            for (i = 0; i < ne + ns; i++) begin
                it = rnd_item();
                if (i < ne || $urandom_range(0, 9) == 0) begin
                    it.kind = KIND_ADD;
                    if ($urandom_range(0, 9) != 0) begin
                        it.end_first = 10'($urandom_range(0, lim));
                        it.end_second = 10'($urandom_range(0, lim));
                    end
                    if ($urandom_range(0, 1)) it.edge_weight = $urandom_range(0, 20);
                end else begin
                    it.kind = ($urandom_range(0, 29) == 0) ? 2'd3 : KIND_SOLVE;
                    if ($urandom_range(0, 7) != 0 && lim > 0) begin
                        it.terminal_a = 10'($urandom_range(0, lim - 1));
                        it.terminal_b = 10'($urandom_range(0, lim - 1));
                        it.terminal_c = 10'($urandom_range(0, lim - 1));
                    end
                end
                send(it);
            end
            ph++;
            if (ph % 7 == 0) drain();
        end
        drain();
        repeat (50) @(posedge i_clk);

        $display("%0d transfers sent, %0d routes checked (%0d found), graphs cleared and kept",
                 transfers, routes_seen, found_seen);
        $display("node counts from zero to above the node limit, stray terminals and endpoints");
        if (errors == 0 && pending_routes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
